@@ src/itoa_fmt_pkg.sv @@
// itoa_fmt_pkg: commands, sizes and the digit-to-ascii map for the integer formatter
// no dependencies; imported by integer_to_ascii_formatter
package itoa_fmt_pkg;

   // operand and result limits
   localparam int VALUE_W      = 32;
   localparam int MAX_PAD      = 32;
   localparam int RESULT_LIMIT = 32;
   localparam int PAD_CAP      = (MAX_PAD < RESULT_LIMIT) ? MAX_PAD : RESULT_LIMIT;

   // digit store: ten bcd digits cover 32 bits, eight hex digits fit inside
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = 8;
   localparam int DIG_W      = DEC_DIGITS * 4;
   localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);

   // counters
   localparam int CONV_W = $clog2(VALUE_W);
   localparam int CNT_W  = $clog2(RESULT_LIMIT + 1);
   localparam int IDX_W  = $clog2(RESULT_LIMIT);

   typedef enum logic [2:0] {
      CMD_UDEC = 3'd0,
      CMD_SDEC = 3'd1,
      CMD_HEXL = 3'd2,
      CMD_HEXU = 3'd3,
      CMD_PTR  = 3'd4
   } cmd_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;

   // one digit to its ascii code
   function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UP_A : CHAR_LOW_A;
      if (nib < 4'd10) begin
         digit_char = CHAR_ZERO + {4'd0, nib};
      end else begin
         digit_char = base + {4'd0, nib} - 8'd10;
      end
   endfunction

endpackage

@@ src/integer_to_ascii_formatter.sv @@
// integer_to_ascii_formatter: formats a 32-bit value as decimal, hex or pointer text,
// one ascii character per response, most significant first; depends on itoa_fmt_pkg
module integer_to_ascii_formatter
   import itoa_fmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_command,
   input  logic [31:0]  req_value,
   input  logic [5:0]   req_pad_width,
   output logic         rsp_valid,
   output logic [7:0]   rsp_character,
   output logic         rsp_last
);

   // channel   | ports                                    | transfer when
   // ----------+------------------------------------------+---------------------------
   // request   | req_command, req_value, req_pad_width    | start high and busy low
   // response  | rsp_character, rsp_last                  | rsp_valid high (one cycle)
   //
   // decimal commands run a bit-serial double-dabble: one operand bit per cycle
   // over the whole operand, then a step to size the field; hex and pointer skip the
   // conversion. after that one character leaves per cycle. reset returns to
   // idle with no strobe; the receiver cannot stall, so characters stream out
   // back to back. commands five to seven are taken and dropped.

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_SIGN,
      ST_PFX0,
      ST_PFXX,
      ST_DIGIT
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic                 neg_ff, neg_in;
   logic [5:0]           pad_ff, pad_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic [CONV_W-1:0]    conv_ff, conv_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_character_ff, rsp_character_in;
   logic                 rsp_last_ff, rsp_last_in;

   // double-dabble correction of every bcd digit
   logic [DIG_W-1:0]     dig_adj;
   // significant digit count of the store, at least one
   logic [CNT_W-1:0]     sig_cnt;
   logic [CNT_W-1:0]     field_cnt;
   logic [3:0]           cur_nib;
   logic [5:0]           req_pad_cap;

   assign req_pad_cap = (req_pad_width > 6'(PAD_CAP)) ? 6'(PAD_CAP) : req_pad_width;

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         dig_adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? dig_ff[i*4 +: 4] + 4'd3
                                                        : dig_ff[i*4 +: 4];
      end
   end

   always_comb begin
      sig_cnt = CNT_W'(1);
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (dig_ff[i*4 +: 4] != 4'd0) begin
            sig_cnt = CNT_W'(i + 1);
         end
      end
   end

   // field length: padded for unsigned and hex, fixed for pointer, unpadded for signed decimal
   always_comb begin
      unique case (cmd_ff)
         CMD_UDEC, CMD_HEXL, CMD_HEXU: begin
            field_cnt = (pad_ff > sig_cnt) ? pad_ff : sig_cnt;
         end
         CMD_PTR: begin
            field_cnt = CNT_W'(HEX_DIGITS);
         end
         default: begin
            field_cnt = sig_cnt;
         end
      endcase
   end

   // positions above the store are leading pad zeros
   always_comb begin
      if (idx_ff < IDX_W'(DEC_DIGITS)) begin
         cur_nib = dig_ff[idx_ff[DIG_IDX_W-1:0]*4 +: 4];
      end else begin
         cur_nib = 4'd0;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      neg_in           = neg_ff;
      pad_in           = pad_ff;
      bin_in           = bin_ff;
      dig_in           = dig_ff;
      conv_in          = conv_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in  = cmd_type'(req_command);
               pad_in  = req_pad_cap;
               neg_in  = 1'b0;
               conv_in = '1;
               unique case (req_command)
                  CMD_UDEC: begin
                     bin_in   = req_value;
                     dig_in   = '0;
                     state_in = ST_CONV;
                  end
                  CMD_SDEC: begin
                     // magnitude of the two's complement operand
                     neg_in   = req_value[VALUE_W-1];
                     bin_in   = req_value[VALUE_W-1] ? (~req_value + 32'd1) : req_value;
                     dig_in   = '0;
                     state_in = ST_CONV;
                  end
                  CMD_HEXL, CMD_HEXU, CMD_PTR: begin
                     dig_in   = {{(DIG_W-VALUE_W){1'b0}}, req_value};
                     state_in = ST_SIZE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            // shift one operand bit into the corrected bcd store
            dig_in  = {dig_adj[DIG_W-2:0], bin_ff[VALUE_W-1]};
            bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
            conv_in = conv_ff - CONV_W'(1);
            if (conv_ff == '0) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            idx_in = IDX_W'(field_cnt - CNT_W'(1));
            if (neg_ff) begin
               state_in = ST_SIGN;
            end else if (cmd_ff == CMD_PTR) begin
               state_in = ST_PFX0;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = CHAR_MINUS;
            state_in         = ST_DIGIT;
         end
         ST_PFX0: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = CHAR_ZERO;
            state_in         = ST_PFXX;
         end
         ST_PFXX: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = CHAR_X;
            state_in         = ST_DIGIT;
         end
         ST_DIGIT: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = digit_char(cur_nib, cmd_ff == CMD_HEXU);
            if (idx_ff == '0) begin
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      cmd_ff           <= cmd_in;
      neg_ff           <= neg_in;
      pad_ff           <= pad_in;
      bin_ff           <= bin_in;
      dig_ff           <= dig_in;
      conv_ff          <= conv_in;
      idx_ff           <= idx_in;
      rsp_character_ff <= rsp_character_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
